### rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared constants, codes and helpers for the cluster chain engine.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int DEFAULT_DEPTH = 4096;

  localparam logic [15:0] FREE_MARK = 16'hFFFF;
  localparam logic [15:0] EOF_MARK  = 16'hFFFE;
  localparam logic [15:0] NONE_MARK = 16'hFFFC;

  localparam logic [12:0] REAL_CLUSTERS_RST = 13'd4096;
  localparam logic [4:0]  CLUSTER_SHIFT_RST = 5'd9;
  localparam logic [4:0]  MIN_SHIFT         = 5'd9;

  // function codes
  localparam logic [2:0] FN_READ   = 3'd0;
  localparam logic [2:0] FN_WRITE  = 3'd1;
  localparam logic [2:0] FN_FIND   = 3'd2;
  localparam logic [2:0] FN_COUNT  = 3'd3;
  localparam logic [2:0] FN_TRUNC  = 3'd4;
  localparam logic [2:0] FN_EXTEND = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_SPACE = 3'd3;
  localparam logic [2:0] ST_BROKEN   = 3'd4;

  // register indexes
  localparam logic [1:0] REG_REAL_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_CLUSTER_SHIFT = 2'd1;

  // bytes rounded up to whole clusters; shift is at least 9 so 24 bits hold it
  function automatic logic [23:0] clusters_of(input logic [31:0] bytes,
                                              input logic [4:0] shift);
    logic [31:0] q;
    logic [31:0] mask;
    q    = bytes >> shift;
    mask = (32'd1 << shift) - 32'd1;
    return q[23:0] + {23'd0, ((bytes & mask) != 32'd0)};
  endfunction

endpackage

### rtl/fcc_table.sv
// ----------------------------------------------------------------------------
// fcc_table
// Allocation table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fcc_table #(
  parameter int DEPTH = fcc_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fat_cluster_chain_engine_unit.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_unit
// Allocation table engine: read, write, find, count, truncate and extend.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | func, address, value, old_size, req_size
// out     | out       | out_valid/out_ready  | read_value .. status
//
// One transaction at a time. A read passes through S_READ to S_DONE, a write goes
// straight to S_DONE; find and count read one entry per cycle. Truncate walks each
// link through S_TR_CHK and S_TR_WR; extend walks links through S_EX_LOOP and
// S_EX_NXT and allocates by a free scan that resumes past the last entry taken.
// After reset a clearing pass frees all TABLE_DEPTH entries, one per cycle, before
// the first transaction. A held result stalls the core in its done state.
module fat_cluster_chain_engine_unit #(
  parameter int TABLE_DEPTH = fcc_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [15:0] address,
  input  logic [15:0] value,
  input  logic [31:0] old_size,
  input  logic [31:0] req_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_value,
  output logic        found,
  output logic [11:0] found_index,
  output logic [12:0] match_count,
  output logic [15:0] chain_begin,
  output logic [31:0] final_size,
  output logic [2:0]  status
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_READ    = 11'b00000000100,
    S_SCAN    = 11'b00000001000,
    S_TR_CHK  = 11'b00000010000,
    S_TR_WR   = 11'b00000100000,
    S_TR_END  = 11'b00001000000,
    S_EX_LOOP = 11'b00010000000,
    S_EX_NXT  = 11'b00100000000,
    S_EX_LNK  = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [12:0] real_clusters;
  logic [4:0]  cluster_shift;
  logic [4:0]  eff_shift;
  logic [16:0] r_use;

  logic [2:0]  func_q, func_q_next;
  logic [15:0] addr_q, addr_q_next;
  logic [15:0] val_q, val_q_next;
  logic [31:0] olds_q, olds_q_next;
  logic [31:0] news_q, news_q_next;
  logic [23:0] cb, cb_next;
  logic [23:0] ca, ca_next;
  logic [23:0] i_cnt, i_cnt_next;
  logic [15:0] cur, cur_next;
  logic [15:0] beg, beg_next;
  logic [2:0]  st, st_next;
  logic [16:0] scan_idx, scan_idx_next;
  logic        pend, pend_next;
  logic [15:0] pend_idx, pend_idx_next;
  logic [12:0] cnt, cnt_next;
  logic        ex_start, ex_start_next;
  logic [16:0] clr_idx, clr_idx_next;

  logic [15:0] res_read, res_read_next;
  logic        res_found, res_found_next;
  logic [11:0] res_fidx, res_fidx_next;
  logic [12:0] res_cnt, res_cnt_next;
  logic [15:0] res_beg, res_beg_next;
  logic [31:0] res_fs, res_fs_next;
  logic [2:0]  res_st, res_st_next;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, rdata;

  logic [23:0] cb_in, ca_in;
  logic [15:0] target;
  logic        accept, out_free;
  logic [31:0] fs_alloc;

  fcc_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign eff_shift = (cluster_shift < fcc_pkg::MIN_SHIFT) ? fcc_pkg::MIN_SHIFT : cluster_shift;
  assign r_use     = ({4'd0, real_clusters} > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH)
                                                               : {4'd0, real_clusters};
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cb_in     = fcc_pkg::clusters_of(old_size, eff_shift);
  assign ca_in     = fcc_pkg::clusters_of(req_size, eff_shift);
  assign target    = ((func_q == fcc_pkg::FN_FIND) || (func_q == fcc_pkg::FN_COUNT))
                     ? val_q : fcc_pkg::FREE_MARK;
  assign fs_alloc  = ({8'd0, i_cnt} << eff_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      real_clusters <= fcc_pkg::REAL_CLUSTERS_RST;
      cluster_shift <= fcc_pkg::CLUSTER_SHIFT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == fcc_pkg::REG_REAL_CLUSTERS) begin
        real_clusters <= cfg_data;
      end else if (cfg_index == fcc_pkg::REG_CLUSTER_SHIFT) begin
        cluster_shift <= cfg_data[4:0];
      end
    end
  end

  always_comb begin
    state_next     = state;
    func_q_next    = func_q;
    addr_q_next    = addr_q;
    val_q_next     = val_q;
    olds_q_next    = olds_q;
    news_q_next    = news_q;
    cb_next        = cb;
    ca_next        = ca;
    i_cnt_next     = i_cnt;
    cur_next       = cur;
    beg_next       = beg;
    st_next        = st;
    scan_idx_next  = scan_idx;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    cnt_next       = cnt;
    ex_start_next  = ex_start;
    clr_idx_next   = clr_idx;
    res_read_next  = res_read;
    res_found_next = res_found;
    res_fidx_next  = res_fidx;
    res_cnt_next   = res_cnt;
    res_beg_next   = res_beg;
    res_fs_next    = res_fs;
    res_st_next    = res_st;
    mem_we         = 1'b0;
    mem_waddr      = cur[AW-1:0];
    mem_wdata      = fcc_pkg::FREE_MARK;
    mem_re         = 1'b0;
    mem_raddr      = cur[AW-1:0];

    case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx[AW-1:0];
        mem_wdata    = fcc_pkg::FREE_MARK;
        clr_idx_next = clr_idx + 17'd1;
        if (clr_idx == 17'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          func_q_next    = func;
          addr_q_next    = address;
          val_q_next     = value;
          olds_q_next    = old_size;
          news_q_next    = req_size;
          cb_next        = cb_in;
          ca_next        = ca_in;
          cur_next       = address;
          beg_next       = address;
          st_next        = fcc_pkg::ST_OK;
          i_cnt_next     = 24'd1;
          scan_idx_next  = 17'd0;
          pend_next      = 1'b0;
          cnt_next       = 13'd0;
          ex_start_next  = 1'b0;
          res_read_next  = 16'd0;
          res_found_next = 1'b0;
          res_fidx_next  = 12'd0;
          res_cnt_next   = 13'd0;
          res_beg_next   = 16'd0;
          res_fs_next    = 32'd0;
          res_st_next    = fcc_pkg::ST_OK;
          state_next     = S_DONE;
          case (func)
            fcc_pkg::FN_READ, fcc_pkg::FN_WRITE: begin
              if ({1'b0, address} >= r_use) begin
                res_st_next = fcc_pkg::ST_RANGE;
              end else if (func == fcc_pkg::FN_WRITE) begin
                mem_we    = 1'b1;
                mem_waddr = address[AW-1:0];
                mem_wdata = value;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = address[AW-1:0];
                state_next = S_READ;
              end
            end
            fcc_pkg::FN_FIND, fcc_pkg::FN_COUNT: begin
              state_next = S_SCAN;
            end
            fcc_pkg::FN_TRUNC: begin
              res_beg_next = address;
              if (req_size >= old_size) begin
                res_fs_next = old_size;
                res_st_next = fcc_pkg::ST_BAD_SIZE;
              end else if (cb_in == ca_in) begin
                res_fs_next = req_size;
              end else begin
                state_next = S_TR_CHK;
              end
            end
            fcc_pkg::FN_EXTEND: begin
              res_beg_next = address;
              if (req_size <= old_size) begin
                res_fs_next = old_size;
                res_st_next = fcc_pkg::ST_BAD_SIZE;
              end else if (cb_in == ca_in) begin
                res_fs_next = req_size;
              end else if (old_size == 32'd0) begin
                ex_start_next = 1'b1;
                state_next    = S_SCAN;
              end else begin
                state_next = S_EX_LOOP;
              end
            end
            default: begin
              res_st_next = fcc_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_READ: begin
        res_read_next = rdata;
        state_next    = S_DONE;
      end

      S_SCAN: begin
        if (pend && (rdata == target) && (func_q == fcc_pkg::FN_COUNT)) begin
          cnt_next = cnt + 13'd1;
        end
        if (pend && (rdata == target) && (func_q != fcc_pkg::FN_COUNT)) begin
          pend_next = 1'b0;
          if (func_q == fcc_pkg::FN_FIND) begin
            res_found_next = 1'b1;
            res_fidx_next  = pend_idx[11:0];
            state_next     = S_DONE;
          end else if (ex_start) begin
            mem_we        = 1'b1;
            mem_waddr     = pend_idx[AW-1:0];
            mem_wdata     = fcc_pkg::EOF_MARK;
            beg_next      = pend_idx;
            cur_next      = pend_idx;
            cb_next       = 24'd1;
            i_cnt_next    = 24'd1;
            ex_start_next = 1'b0;
            scan_idx_next = {1'b0, pend_idx} + 17'd1;
            state_next    = S_EX_LOOP;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = cur[AW-1:0];
            mem_wdata  = pend_idx;
            state_next = S_EX_LNK;
          end
        end else if (!pend && (scan_idx >= r_use)) begin
          state_next = S_DONE;
          if (func_q == fcc_pkg::FN_COUNT) begin
            res_cnt_next = cnt;
          end else if (func_q == fcc_pkg::FN_EXTEND) begin
            res_st_next = fcc_pkg::ST_NO_SPACE;
            if (ex_start) begin
              res_beg_next = addr_q;
              res_fs_next  = 32'd0;
            end else begin
              res_beg_next = beg;
              res_fs_next  = fs_alloc;
            end
          end
        end else if (scan_idx < r_use) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_idx[AW-1:0];
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[15:0];
          scan_idx_next = scan_idx + 17'd1;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_TR_CHK: begin
        if (i_cnt > cb) begin
          state_next = S_TR_END;
        end else if (cur == fcc_pkg::EOF_MARK) begin
          st_next    = fcc_pkg::ST_BROKEN;
          state_next = S_TR_END;
        end else if ({1'b0, cur} >= r_use) begin
          res_beg_next = addr_q;
          res_fs_next  = olds_q;
          res_st_next  = fcc_pkg::ST_RANGE;
          state_next   = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = cur[AW-1:0];
          state_next = S_TR_WR;
        end
      end

      S_TR_WR: begin
        mem_waddr = cur[AW-1:0];
        if (i_cnt == ca) begin
          mem_we    = 1'b1;
          mem_wdata = fcc_pkg::EOF_MARK;
        end else if (i_cnt > ca) begin
          mem_we    = 1'b1;
          mem_wdata = fcc_pkg::FREE_MARK;
        end
        cur_next   = rdata;
        i_cnt_next = i_cnt + 24'd1;
        state_next = S_TR_CHK;
      end

      S_TR_END: begin
        res_beg_next = addr_q;
        if (ca == 24'd0) begin
          res_beg_next = fcc_pkg::NONE_MARK;
          if ({1'b0, addr_q} < r_use) begin
            mem_we    = 1'b1;
            mem_waddr = addr_q[AW-1:0];
            mem_wdata = fcc_pkg::FREE_MARK;
          end
        end
        res_fs_next = news_q;
        res_st_next = st;
        state_next  = S_DONE;
      end

      S_EX_LOOP: begin
        if (i_cnt >= ca) begin
          res_beg_next = beg;
          res_fs_next  = news_q;
          res_st_next  = st;
          state_next   = S_DONE;
        end else if ({1'b0, cur} >= r_use) begin
          res_beg_next = beg;
          res_fs_next  = olds_q;
          res_st_next  = fcc_pkg::ST_RANGE;
          state_next   = S_DONE;
        end else if (i_cnt < cb) begin
          mem_re     = 1'b1;
          mem_raddr  = cur[AW-1:0];
          state_next = S_EX_NXT;
        end else begin
          pend_next  = 1'b0;
          state_next = S_SCAN;
        end
      end

      S_EX_NXT: begin
        if (rdata == fcc_pkg::EOF_MARK) begin
          st_next    = fcc_pkg::ST_BROKEN;
          cb_next    = i_cnt;
          pend_next  = 1'b0;
          state_next = S_SCAN;
        end else begin
          cur_next   = rdata;
          i_cnt_next = i_cnt + 24'd1;
          state_next = S_EX_LOOP;
        end
      end

      S_EX_LNK: begin
        mem_we        = 1'b1;
        mem_waddr     = pend_idx[AW-1:0];
        mem_wdata     = fcc_pkg::EOF_MARK;
        cur_next      = pend_idx;
        scan_idx_next = {1'b0, pend_idx} + 17'd1;
        i_cnt_next    = i_cnt + 24'd1;
        state_next    = S_EX_LOOP;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= 17'd0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    func_q    <= func_q_next;
    addr_q    <= addr_q_next;
    val_q     <= val_q_next;
    olds_q    <= olds_q_next;
    news_q    <= news_q_next;
    cb        <= cb_next;
    ca        <= ca_next;
    i_cnt     <= i_cnt_next;
    cur       <= cur_next;
    beg       <= beg_next;
    st        <= st_next;
    scan_idx  <= scan_idx_next;
    pend_idx  <= pend_idx_next;
    cnt       <= cnt_next;
    ex_start  <= ex_start_next;
    res_read  <= res_read_next;
    res_found <= res_found_next;
    res_fidx  <= res_fidx_next;
    res_cnt   <= res_cnt_next;
    res_beg   <= res_beg_next;
    res_fs    <= res_fs_next;
    res_st    <= res_st_next;
  end

  // output register: loaded from the result holding regs when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      read_value  <= res_read;
      found       <= res_found;
      found_index <= res_fidx;
      match_count <= res_cnt;
      chain_begin <= res_beg;
      final_size  <= res_fs;
      status      <= res_st;
    end
  end

endmodule
